FILE: rtl/dksc_pkg.sv
// shared types and constants for the debounced key sweep controller
// used by every module of the block and by its checker
package dksc_pkg;

  // key debouncer timing, in sweep ticks
  localparam logic [3:0] DEBOUNCE_TICKS = 4'd10;

  // arithmetic on frequency settings is done at this signed width
  typedef logic signed [10:0] fcalc_t;

  localparam fcalc_t FREQ_LIMIT       = 11'sd400;
  localparam fcalc_t FREQ_MIN         = 11'sd10;
  localparam fcalc_t FREQ_INC         = 11'sd10;
  localparam fcalc_t FREQ_SAT         = 11'sd511;
  localparam fcalc_t STEP_MAX         = 11'sd51;
  localparam fcalc_t STEP_INC         = 11'sd5;
  localparam fcalc_t STEP_MIN         = 11'sd1;

  // reset values of the settings and tracking registers
  localparam logic [5:0] STEP_RST     = 6'd1;
  localparam logic [8:0] START_RST    = 9'd10;
  localparam logic [8:0] STOP_RST     = 9'd400;
  localparam logic [8:0] SINGLE_RST   = 9'd200;
  localparam logic [8:0] POINT_RST    = 9'd10;
  localparam logic [8:0] BAND_LO_DFLT = 9'd10;
  localparam logic [8:0] BAND_HI_DFLT = 9'd400;

  // gains in 1/16 dB
  localparam logic signed [11:0] PEAK_RESET = -12'sd1600;
  localparam logic signed [12:0] DROP_3DB   = 13'sd48;
  localparam logic signed [12:0] GAIN_MIN   = -13'sd2048;

  // debouncer phases
  typedef enum logic [2:0] {
    KP_WAIT = 3'd1,
    KP_DLY  = 3'd2,
    KP_TEST = 3'd3,
    KP_EXE  = 3'd4,
    KP_UP   = 3'd5
  } key_phase_t;

  // menu modes
  typedef enum logic [2:0] {
    MODE_STEP   = 3'd0,
    MODE_START  = 3'd1,
    MODE_STOP   = 3'd2,
    MODE_SINGLE = 3'd3,
    MODE_ZERO   = 3'd4
  } menu_mode_t;

  // band tracking phases
  typedef enum logic [1:0] {
    BP_SEEK = 2'd0,
    BP_IN   = 2'd1,
    BP_DONE = 2'd2
  } band_phase_t;

  // sweep settings as seen after this tick's key actions
  typedef struct packed {
    menu_mode_t mode;
    logic [5:0] step_size;
    logic [8:0] start_freq;
    logic [8:0] stop_freq;
    logic [8:0] single_freq;
  } settings_t;

  // one result item
  typedef struct packed {
    logic [8:0] point_freq;
    logic [8:0] drive_freq;
    menu_mode_t menu_mode;
    logic       report_valid;
    logic [8:0] peak_freq;
    logic [8:0] band_start;
    logic [8:0] band_end;
    logic [8:0] band_width;
  } result_t;

  // key events of one tick
  typedef struct packed {
    logic mode_fire;
    logic up_fire;
    logic down_fire;
  } key_fire_t;

endpackage

FILE: rtl/dksc_debounce.sv
// one key debouncer: wait, delay, test, execute, wait for release
// phases may fall through several steps within one tick; uses dksc_pkg
module dksc_debounce (
  input  logic clk,
  input  logic rst_n,
  input  logic step_en,
  input  logic level,
  output logic fired
);
  import dksc_pkg::*;

  key_phase_t phase_r, phase_nxt;
  logic [3:0] delay_r, delay_nxt;
  logic [3:0] delay_inc;
  logic       reach_test;

  assign delay_inc = delay_r + 4'd1;

  // next phase, checked once per phase in order
  always_comb begin
    phase_nxt = phase_r;
    delay_nxt = delay_r;
    if (phase_nxt == KP_WAIT && level) begin
      phase_nxt = KP_DLY;
    end
    if (phase_nxt == KP_DLY) begin
      delay_nxt = delay_inc;
      if (delay_inc == DEBOUNCE_TICKS) begin
        delay_nxt = '0;
        phase_nxt = KP_TEST;
      end
    end
    if (phase_nxt == KP_TEST) begin
      phase_nxt = level ? KP_EXE : KP_WAIT;
    end
    if (phase_nxt == KP_EXE) begin
      phase_nxt = KP_UP;
    end
    if (phase_nxt == KP_UP && !level) begin
      phase_nxt = KP_WAIT;
    end
  end

  // key event: execute phase is reached during this tick
  always_comb begin
    reach_test = 1'b0;
    unique case (phase_r)
      KP_WAIT: reach_test = level && (delay_inc == DEBOUNCE_TICKS);
      KP_DLY:  reach_test = (delay_inc == DEBOUNCE_TICKS);
      KP_TEST: reach_test = 1'b1;
      default: reach_test = 1'b0;
    endcase
    fired = (phase_r == KP_EXE) || (reach_test && level);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= KP_WAIT;
      delay_r <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      delay_r <= delay_nxt;
    end
  end

endmodule

FILE: rtl/dksc_settings.sv
// menu mode and sweep settings, changed by debounced key events
// presents the settings as they stand after this tick's keys; uses dksc_pkg
module dksc_settings (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  dksc_pkg::key_fire_t fire,
  output dksc_pkg::settings_t set_nxt
);
  import dksc_pkg::*;

  menu_mode_t mode_r;
  logic [5:0] step_r;
  logic [8:0] start_r;
  logic [8:0] stop_r;
  logic [8:0] single_r;

  // key actions: mode key first, then up, then down
  always_comb begin
    menu_mode_t mode_v;
    fcalc_t     step_v;
    fcalc_t     start_v;
    fcalc_t     stop_v;
    fcalc_t     single_v;
    mode_v   = mode_r;
    step_v   = fcalc_t'({5'd0, step_r});
    start_v  = fcalc_t'({2'd0, start_r});
    stop_v   = fcalc_t'({2'd0, stop_r});
    single_v = fcalc_t'({2'd0, single_r});

    if (fire.mode_fire) begin
      unique case (mode_v)
        MODE_STEP:   mode_v = MODE_START;
        MODE_START:  mode_v = MODE_STOP;
        MODE_STOP:   mode_v = MODE_SINGLE;
        MODE_SINGLE: mode_v = MODE_ZERO;
        default:     mode_v = MODE_STEP;
      endcase
    end

    if (fire.up_fire) begin
      unique case (mode_v)
        MODE_STEP: begin
          step_v = step_v + STEP_INC;
          if (step_v > STEP_MAX) step_v = STEP_MIN;
        end
        MODE_START: begin
          start_v = start_v + FREQ_INC;
          if (stop_v - step_v < start_v) start_v = stop_v - step_v;
          if (start_v < FREQ_MIN) start_v = FREQ_MIN;
        end
        MODE_STOP: begin
          stop_v = stop_v + FREQ_INC;
          if (stop_v > FREQ_LIMIT) stop_v = FREQ_LIMIT;
        end
        MODE_SINGLE: begin
          single_v = single_v + FREQ_INC;
          if (single_v > FREQ_LIMIT) single_v = FREQ_LIMIT;
        end
        default: ;
      endcase
    end

    if (fire.down_fire) begin
      unique case (mode_v)
        MODE_STEP: begin
          step_v = step_v - STEP_INC;
          if (step_v < STEP_MIN) step_v = STEP_MIN;
        end
        MODE_START: begin
          start_v = start_v - FREQ_INC;
          if (start_v < FREQ_MIN) start_v = FREQ_MIN;
        end
        MODE_STOP: begin
          stop_v = stop_v - FREQ_INC;
          if (start_v + step_v > stop_v) stop_v = start_v + step_v;
          if (stop_v > FREQ_SAT) stop_v = FREQ_SAT;
        end
        MODE_SINGLE: begin
          single_v = single_v - FREQ_INC;
          if (single_v < FREQ_MIN) single_v = FREQ_MIN;
          if (single_v > FREQ_LIMIT) single_v = FREQ_LIMIT;
        end
        default: mode_v = MODE_STEP;
      endcase
    end

    set_nxt.mode        = mode_v;
    set_nxt.step_size   = step_v[5:0];
    set_nxt.start_freq  = start_v[8:0];
    set_nxt.stop_freq   = stop_v[8:0];
    set_nxt.single_freq = single_v[8:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_STEP;
      step_r   <= STEP_RST;
      start_r  <= START_RST;
      stop_r   <= STOP_RST;
      single_r <= SINGLE_RST;
    end else if (step_en) begin
      mode_r   <= set_nxt.mode;
      step_r   <= set_nxt.step_size;
      start_r  <= set_nxt.start_freq;
      stop_r   <= set_nxt.stop_freq;
      single_r <= set_nxt.single_freq;
    end
  end

endmodule

FILE: rtl/dksc_track.sv
// sweep point stepping, peak and band tracking, end-of-sweep report
// takes the post-key settings from dksc_settings; uses dksc_pkg
module dksc_track (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic signed [11:0]  gain_db,
  input  dksc_pkg::settings_t set_nxt,
  output dksc_pkg::result_t   res
);
  import dksc_pkg::*;

  logic [8:0]         point_r, point_nxt;
  logic signed [11:0] peak_gain_r, peak_gain_nxt;
  logic [8:0]         peak_point_r, peak_point_nxt;
  logic signed [11:0] thr_r, thr_nxt;
  band_phase_t        band_r, band_nxt;
  logic [8:0]         band_lo_r, band_lo_nxt;
  logic [8:0]         band_hi_r, band_hi_nxt;

  logic               active;
  logic               sweep_end;
  logic               report;
  logic               peak_upd;
  logic signed [11:0] pk_gain_v;
  logic [8:0]         pk_point_v;
  band_phase_t        band_v;
  logic [8:0]         lo_v;
  logic [8:0]         hi_v;
  logic signed [12:0] thr_calc;
  logic signed [9:0]  width_calc;
  logic [9:0]         point_sum;

  assign active    = (set_nxt.mode != MODE_SINGLE);
  assign sweep_end = (point_r[8:1] >= set_nxt.stop_freq[8:1]);
  assign report    = active && sweep_end;

  // peak and band crossing updates for this point
  always_comb begin
    peak_upd   = (gain_db > peak_gain_r);
    pk_gain_v  = peak_upd ? gain_db : peak_gain_r;
    pk_point_v = peak_upd ? point_r : peak_point_r;
    band_v     = band_r;
    lo_v       = band_lo_r;
    hi_v       = band_hi_r;
    if (band_v == BP_SEEK && gain_db > thr_r) begin
      band_v = BP_IN;
      lo_v   = point_r;
    end
    if (band_v == BP_IN && gain_db < thr_r) begin
      band_v = BP_DONE;
      hi_v   = point_r;
    end
  end

  // new threshold 3 dB under the peak, saturated
  always_comb begin
    thr_calc = {pk_gain_v[11], pk_gain_v} - DROP_3DB;
    if (thr_calc < GAIN_MIN) thr_calc = GAIN_MIN;
  end

  // band width, negative shown as zero
  assign width_calc = $signed({1'b0, hi_v}) - $signed({1'b0, lo_v});

  // next tracking state
  always_comb begin
    peak_gain_nxt  = peak_gain_r;
    peak_point_nxt = peak_point_r;
    thr_nxt        = thr_r;
    band_nxt       = band_r;
    band_lo_nxt    = band_lo_r;
    band_hi_nxt    = band_hi_r;
    if (active) begin
      peak_point_nxt = pk_point_v;
      if (sweep_end) begin
        thr_nxt       = thr_calc[11:0];
        peak_gain_nxt = PEAK_RESET;
        band_lo_nxt   = BAND_LO_DFLT;
        band_hi_nxt   = BAND_HI_DFLT;
        band_nxt      = BP_SEEK;
      end else begin
        peak_gain_nxt = pk_gain_v;
        band_lo_nxt   = lo_v;
        band_hi_nxt   = hi_v;
        band_nxt      = band_v;
      end
    end
  end

  // sweep advance, back to start past the stop point
  always_comb begin
    point_sum = {1'b0, point_r} + {4'd0, set_nxt.step_size};
    if (point_sum > {1'b0, set_nxt.stop_freq}) begin
      point_nxt = set_nxt.start_freq;
    end else begin
      point_nxt = point_sum[8:0];
    end
  end

  // result of this tick
  always_comb begin
    res.point_freq   = point_r;
    res.drive_freq   = active ? point_r : set_nxt.single_freq;
    res.menu_mode    = set_nxt.mode;
    res.report_valid = report;
    res.peak_freq    = report ? pk_point_v : '0;
    res.band_start   = report ? lo_v : '0;
    res.band_end     = report ? hi_v : '0;
    res.band_width   = (report && !width_calc[9]) ? width_calc[8:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_r      <= POINT_RST;
      peak_gain_r  <= '0;
      peak_point_r <= '0;
      thr_r        <= '0;
      band_r       <= BP_SEEK;
      band_lo_r    <= '0;
      band_hi_r    <= '0;
    end else if (step_en) begin
      point_r      <= point_nxt;
      peak_gain_r  <= peak_gain_nxt;
      peak_point_r <= peak_point_nxt;
      thr_r        <= thr_nxt;
      band_r       <= band_nxt;
      band_lo_r    <= band_lo_nxt;
      band_hi_r    <= band_hi_nxt;
    end
  end

endmodule

FILE: rtl/debounced_key_sweep_controller.sv
// top level of the debounced key sweep controller
// instantiates dksc_debounce (x3), dksc_settings, dksc_track; uses dksc_pkg
//
//   channel   | dir | handshake            | payload
//   ----------+-----+----------------------+----------------------------------------
//   in_*      | in  | in_tvalid/in_tready  | one sweep tick: three key levels, gain
//   out_*     | out | out_tvalid/out_tready| point, drive, mode, report (tuser flag)
//
// one item per cycle sustained while out_tready stays high; an accepted item is held in the input
// register, then processed into the output register
// input and output registers decouple the sides: an item is taken while a result
// waits, and the input register stalls only when the output register is full
// synchronous active-low reset returns all keys, settings and tracking to defaults
module debounced_key_sweep_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [0] mode_key, [1] up_key, [2] down_key, [14:3] gain_db
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [8:0] point_freq, [17:9] drive_freq, [20:18] menu_mode,
                                  // [29:21] peak_freq, [38:30] band_start,
                                  // [47:39] band_end, [56:48] band_width
  output logic [0:0]  out_tuser   // [0] report_valid
);
  import dksc_pkg::*;

  logic               in_valid_r, in_valid_nxt;
  logic [14:0]        in_data_r;
  logic               out_valid_r, out_valid_nxt;
  result_t            out_data_r;
  logic               advance;
  key_fire_t          fire;
  settings_t          set_nxt;
  result_t            res;

  // one tick is processed when the output register is free or draining
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  assign in_valid_nxt  = (in_tvalid && in_tready) || (in_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_tready);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata[14:0];
    end
    if (advance) begin
      out_data_r <= res;
    end
  end

  // key debouncers
  dksc_debounce u_mode_key (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .level   (in_data_r[0]),
    .fired   (fire.mode_fire)
  );

  dksc_debounce u_up_key (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .level   (in_data_r[1]),
    .fired   (fire.up_fire)
  );

  dksc_debounce u_down_key (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .level   (in_data_r[2]),
    .fired   (fire.down_fire)
  );

  dksc_settings u_settings (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .fire    (fire),
    .set_nxt (set_nxt)
  );

  dksc_track u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .gain_db ($signed(in_data_r[14:3])),
    .set_nxt (set_nxt),
    .res     (res)
  );

  // output packing
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0,
                       out_data_r.band_width,
                       out_data_r.band_end,
                       out_data_r.band_start,
                       out_data_r.peak_freq,
                       out_data_r.menu_mode,
                       out_data_r.drive_freq,
                       out_data_r.point_freq};
  assign out_tuser  = out_data_r.report_valid;

endmodule

FILE: rtl/dksc_checker.sv
// port-level checker for the debounced key sweep controller, with its bind
// sees only the top-level ports; uses dksc_pkg
module dksc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [0:0]  out_tuser
);
  import dksc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // no report in single-tone mode
  a_no_report_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[20:18] != MODE_SINGLE)
    else $error("report in single-tone mode");

  // report fields are zero without a report
  a_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[56:21] == '0)
    else $error("report fields set without report");

  // drive follows the sweep point outside single-tone mode
  a_drive_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[20:18] != MODE_SINGLE |-> out_tdata[17:9] == out_tdata[8:0])
    else $error("drive frequency differs from sweep point");

  // band width matches its ends
  a_band_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      out_tdata[56:48] == ((out_tdata[47:39] >= out_tdata[38:30]) ?
                           (out_tdata[47:39] - out_tdata[38:30]) : 9'd0))
    else $error("band width inconsistent with band ends");

endmodule

bind debounced_key_sweep_controller dksc_checker u_dksc_checker (.*);
